>>> design/kwm_pkg.sv
package kwm_pkg;

   localparam int LISTS       = 8;
   localparam int DEPTH       = 8;
   localparam int VALUE_W     = 32;
   localparam int IDX_W       = 3;
   localparam int LIST_W      = $clog2(LISTS);
   localparam int POS_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W       = $clog2(DEPTH + 1);
   localparam int NEXT_W      = LEN_W + 1;
   localparam int STORE_DEPTH = LISTS * DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // one list head held by a cell; an invalid entry ranks after every valid one
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic [LIST_W-1:0]         list;
      logic [POS_W-1:0]          pos;
      logic [LEN_W-1:0]          len;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      replace;
      entry_type key;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FILL,
      ST_FILL_END,
      ST_POP,
      ST_REPL
   } state_type;

   // order by value, then by list number
   function automatic logic entry_less(entry_type a, entry_type b);
      logic r;
      if (!a.valid) begin
         r = 1'b0;
      end else if (!b.valid) begin
         r = 1'b1;
      end else if (a.value != b.value) begin
         r = (a.value < b.value);
      end else begin
         r = (a.list < b.list);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(logic [LIST_W-1:0] l,
                                                    logic [POS_W-1:0] p);
      return ADDR_W'(ADDR_W'(l) * ADDR_W'(DEPTH)) + ADDR_W'(p);
   endfunction

endpackage

>>> design/kwm_req_if.sv
interface kwm_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [2:0]         list_index;
   logic               load_last;

   modport source (output valid, output value, output list_index, output load_last,
                   input ready);
   modport sink (input valid, input value, input list_index, input load_last,
                 output ready);
endinterface

>>> design/kwm_rsp_if.sv
interface kwm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] merged_value;
   logic [2:0]         source_list;
   logic               run_last;
   logic               overflowed;

   modport source (output valid, output merged_value, output source_list,
                   output run_last, output overflowed, input ready);
   modport sink (input valid, input merged_value, input source_list,
                 input run_last, input overflowed, output ready);
endinterface

>>> design/kwm_ram.sv
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/kwm_cell.sv
module kwm_cell import kwm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          is_first,
   input  cell_ctrl_type ctrl,
   input  entry_type     prev_entry,
   input  logic          prev_below,
   input  entry_type     next_entry,
   input  logic          next_below,
   output entry_type     entry,
   output logic          below
);

   entry_type entry_ff;
   entry_type entry_in;

   // below: this cell's head ranks ahead of the broadcast key
   assign below = entry_less(entry_ff, ctrl.key);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         // shift right from the insertion point
         if (!below) begin
            entry_in = prev_below ? ctrl.key : prev_entry;
         end
      end else if (ctrl.replace) begin
         // drop the head, shift left, key lands where it belongs
         if (next_below) begin
            entry_in = next_entry;
         end else if (is_first || below) begin
            entry_in = ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

>>> design/k_way_sorted_merge_top.sv
// k-way sorted merge.
// req_chan carries one element per transfer: value, its list_index and
// load_last. Elements are appended to their list (up to DEPTH each; extra ones
// are dropped and raise overflowed for the run). A list_index of LISTS or more
// is ignored. One element is taken per cycle while loading.
// The transfer with load_last set closes the data set. req_chan.ready then
// drops for the whole merge. The heads of all non-empty lists are loaded into
// a sorted row of LISTS cells, then rsp_chan gives the merged ascending run,
// lower list first on equal values, run_last on the final result. A result
// whose list still has elements is followed by an element store read, then a
// replace-min in the cell row; one whose list is exhausted pops the head at
// once. An empty head closes the merge and ready returns.
// A stalled receiver holds the result register and freezes the merge.
// Synchronous reset empties all lists, the cell row and the result register.
module k_way_sorted_merge_top import kwm_pkg::*; (
   input logic       clock,
   input logic       reset,
   kwm_req_if.sink   req_chan,
   kwm_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;

   logic [LEN_W-1:0]  list_len_ff [LISTS];
   logic              ovf_ff;
   logic [LIST_W-1:0] fill_idx_ff;
   logic              fill_pend_ff, fill_pend_in;
   logic [LIST_W-1:0] fill_list_ff;
   logic [LEN_W-1:0]  fill_len_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [2:0]         rsp_list_ff;
   logic               rsp_last_ff;
   logic               rsp_ovf_ff;

   entry_type     cell_entry [LISTS];
   logic          cell_below [LISTS];
   cell_ctrl_type ctrl;

   logic              accept;
   logic              in_range;
   logic [LIST_W-1:0] len_sel;
   logic [LEN_W-1:0]  cur_len;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       rd_data;

   entry_type        head;
   logic [POS_W-1:0] head_next_pos;
   logic             has_next;
   logic             slot_free;
   logic             emit;
   logic             merge_done;

   assign head          = cell_entry[0];
   assign head_next_pos = POS_W'(head.pos + 1'b1);
   assign has_next      = (NEXT_W'(head.pos) + NEXT_W'(1)) < NEXT_W'(head.len);
   assign slot_free     = !rsp_valid_ff || rsp_chan.ready;

   assign accept   = req_chan.valid && req_chan.ready;
   assign in_range = int'(req_chan.list_index) < LISTS;
   assign len_sel  = (state_ff == ST_LOAD) ? LIST_W'(req_chan.list_index) : fill_idx_ff;
   assign cur_len  = list_len_ff[len_sel];
   assign wr_en    = accept && in_range && (cur_len < LEN_W'(DEPTH));
   assign wr_addr  = store_addr(LIST_W'(req_chan.list_index), POS_W'(cur_len));
   assign rd_addr  = (state_ff == ST_FILL) ? store_addr(fill_idx_ff, '0)
                                           : store_addr(head.list, head_next_pos);

   kwm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   for (genvar i = 0; i < LISTS; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_b, next_b;
      if (i == 0) begin : g_head
         assign prev_e = '0;
         assign prev_b = 1'b1;
      end else begin : g_prev
         assign prev_e = cell_entry[i-1];
         assign prev_b = cell_below[i-1];
      end
      if (i == LISTS - 1) begin : g_tail
         assign next_e = '0;
         assign next_b = 1'b0;
      end else begin : g_next
         assign next_e = cell_entry[i+1];
         assign next_b = cell_below[i+1];
      end
      kwm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .is_first   (i == 0),
         .ctrl       (ctrl),
         .prev_entry (prev_e),
         .prev_below (prev_b),
         .next_entry (next_e),
         .next_below (next_b),
         .entry      (cell_entry[i]),
         .below      (cell_below[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_chan.load_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (fill_idx_ff == LIST_W'(LISTS - 1)) state_in = ST_FILL_END;
         end
         ST_FILL_END: state_in = ST_POP;
         ST_POP: begin
            if (!head.valid) begin
               state_in = ST_LOAD;
            end else if (slot_free && has_next) begin
               state_in = ST_REPL;
            end
         end
         ST_REPL: state_in = ST_POP;
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      emit           = 1'b0;
      merge_done     = 1'b0;
      fill_pend_in   = 1'b0;
      ctrl           = '0;
      if (fill_pend_ff) begin
         ctrl.insert    = 1'b1;
         ctrl.key.valid = 1'b1;
         ctrl.key.value = $signed(rd_data);
         ctrl.key.list  = fill_list_ff;
         ctrl.key.pos   = '0;
         ctrl.key.len   = fill_len_ff;
      end
      unique case (state_ff)
         ST_LOAD: req_chan.ready = 1'b1;
         ST_FILL: fill_pend_in = (cur_len != '0);
         ST_FILL_END: ;
         ST_POP: begin
            merge_done = !head.valid;
            emit       = head.valid && slot_free;
            // exhausted list: pop with an empty key
            if (emit && !has_next) ctrl.replace = 1'b1;
         end
         ST_REPL: begin
            ctrl.replace   = 1'b1;
            ctrl.key.valid = 1'b1;
            ctrl.key.value = $signed(rd_data);
            ctrl.key.list  = head.list;
            ctrl.key.pos   = head_next_pos;
            ctrl.key.len   = head.len;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         ovf_ff       <= 1'b0;
         fill_idx_ff  <= '0;
         fill_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LISTS; i++) list_len_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         fill_pend_ff <= fill_pend_in;
         if (state_ff == ST_FILL) begin
            fill_idx_ff <= fill_idx_ff + 1'b1;
         end else begin
            fill_idx_ff <= '0;
         end
         if (wr_en) list_len_ff[len_sel] <= cur_len + 1'b1;
         if (accept && in_range && (cur_len == LEN_W'(DEPTH))) ovf_ff <= 1'b1;
         if (merge_done) begin
            ovf_ff <= 1'b0;
            for (int i = 0; i < LISTS; i++) list_len_ff[i] <= '0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_list_ff <= fill_idx_ff;
      fill_len_ff  <= cur_len;
      if (emit) begin
         rsp_value_ff <= head.value;
         rsp_list_ff  <= 3'(head.list);
         rsp_last_ff  <= !has_next && !cell_entry[1].valid;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.merged_value = rsp_value_ff;
   assign rsp_chan.source_list  = rsp_list_ff;
   assign rsp_chan.run_last     = rsp_last_ff;
   assign rsp_chan.overflowed   = rsp_ovf_ff;

   a_one_cell_op: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.insert && ctrl.replace))
      else $error("insert and replace in the same cycle");

   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_entry[1].valid |-> entry_less(cell_entry[0], cell_entry[1]))
      else $error("cell row out of order");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_POP))
      else $error("result raised outside pop");

   a_no_load_in_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !wr_en)
      else $error("store written during merge");

endmodule

>>> tb/k_way_sorted_merge_top_test.sv
module k_way_sorted_merge_top_test;
   import kwm_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_ITEMS = 420;
   localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0]          src;
      logic                      run_last;
      logic                      ovf;
   } merged_type;

   // one element transfer; typed rows carry their single expected result
   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0]          list;
      logic                      last;
      bit                        typed;
      logic signed [VALUE_W-1:0] want_value;
      logic [IDX_W-1:0]          want_list;
      logic                      want_ovf;
   } elem_type;

   logic clock;
   logic reset = 1'b1;

   kwm_req_if req_chan();
   kwm_rsp_if rsp_chan();

   k_way_sorted_merge_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   elem_type directed_tbl [22] = '{
      '{VMIN, 3'd0, 1'b1, 1'b1, VMIN, 3'd0, 1'b0},
      '{VMAX, 3'd7, 1'b1, 1'b1, VMAX, 3'd7, 1'b0},
      '{0,    3'd3, 1'b1, 1'b1, 0,    3'd3, 1'b0},
      // list 5 filled to DEPTH, then one more that gets dropped
      '{10, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{20, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{30, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{40, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{50, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{60, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{70, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{80, 3'd5, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{90, 3'd5, 1'b1, 1'b0, 0, 3'd0, 1'b0},
      // flag and list length must be back to zero
      '{1,  3'd5, 1'b1, 1'b1, 1, 3'd5, 1'b0},
      // equal values, lower list first
      '{-1, 3'd6, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{-1, 3'd1, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{-1, 3'd4, 1'b1, 1'b0, 0, 3'd0, 1'b0},
      // unsorted list
      '{5,  3'd2, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{-3, 3'd2, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{7,  3'd2, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{0,  3'd0, 1'b1, 1'b0, 0, 3'd0, 1'b0},
      '{32'sh5555_5555, 3'd1, 1'b0, 1'b0, 0, 3'd0, 1'b0},
      '{32'shaaaa_aaaa, 3'd2, 1'b1, 1'b0, 0, 3'd0, 1'b0}
   };

   // predictor state
   logic signed [VALUE_W-1:0] elem_store [LISTS][DEPTH];
   int      list_fill [LISTS];
   bit      dropped_any;
   merged_type merged_due [$];

   int fail_count;
   int results_checked;
   int sets_merged;
   int overflow_runs;
   int items_sent;
   int cycles;

   int       stall_phase;
   int       stall_mode;
   logic [7:0] stall_pat;

   function automatic void predict_merge(input logic signed [VALUE_W-1:0] v,
                                         input logic [IDX_W-1:0] li,
                                         input logic closes,
                                         output merged_type run [$]);
      int      head [LISTS];
      int      best;
      merged_type r;
      run = {};
      if (int'(li) < LISTS) begin
         if (list_fill[li] < DEPTH) begin
            elem_store[li][list_fill[li]] = v;
            list_fill[li]++;
         end else begin
            dropped_any = 1'b1;
         end
      end
      if (closes) begin
         foreach (head[l]) head[l] = 0;
         // smallest head by (value, list) each round; strict compare keeps lower list on ties
         while (1) begin
            best = -1;
            for (int l = 0; l < LISTS; l++) begin
               if (head[l] < list_fill[l] &&
                   (best < 0 || elem_store[l][head[l]] < elem_store[best][head[best]]))
                  best = l;
            end
            if (best < 0) break;
            r.value    = elem_store[best][head[best]];
            r.src      = IDX_W'(best);
            r.run_last = 1'b0;
            r.ovf      = dropped_any;
            run.insert(run.size(), r);
            head[best]++;
         end
         if (run.size() != 0) run[run.size()-1].run_last = 1'b1;
         sets_merged++;
         if (dropped_any) overflow_runs++;
         foreach (list_fill[l]) list_fill[l] = 0;
         dropped_any = 1'b0;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("k_way_sorted_merge_top regression: fail");
         $finish;
      end
   end

   // receiver: stall mode is redrawn whenever the phase counter runs out
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_pat   <= 8'($urandom) | 8'd1;
         stall_phase <= $urandom_range(20, 80);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: rsp_chan.ready <= stall_pat[stall_phase[2:0]];
         default: rsp_chan.ready <= ($urandom_range(0, 4) != 0);
      endcase
   end

   always @(posedge clock) begin
      merged_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (merged_due.size() == 0) begin
            $error("unexpected result: merged_value %0d source_list %0d",
                   rsp_chan.merged_value, rsp_chan.source_list);
            fail_count++;
         end else begin
            want = merged_due.pop_front();
            results_checked++;
            if (rsp_chan.merged_value !== want.value) begin
               $error("merged_value: expected %0d, actual %0d",
                      want.value, rsp_chan.merged_value);
               fail_count++;
            end
            if (rsp_chan.source_list !== want.src) begin
               $error("source_list: expected %0d, actual %0d",
                      want.src, rsp_chan.source_list);
               fail_count++;
            end
            if (rsp_chan.run_last !== want.run_last) begin
               $error("run_last: expected %0d, actual %0d",
                      want.run_last, rsp_chan.run_last);
               fail_count++;
            end
            if (rsp_chan.overflowed !== want.ovf) begin
               $error("overflowed: expected %0d, actual %0d",
                      want.ovf, rsp_chan.overflowed);
               fail_count++;
            end
         end
      end
   end

   initial begin
      elem_type   stim_q [$];
      elem_type   e;
      merged_type run [$];
      int      vals [LISTS][$];
      int      order [$];
      int      cand [$];
      int      n_directed;
      int      kind;
      int      nl;
      int      style;
      int      cnt;
      int      pick;
      int      v;
      int      burst_left;
      int      gap;

      req_chan.valid      = 1'b0;
      req_chan.value      = '0;
      req_chan.list_index = '0;
      req_chan.load_last  = 1'b0;
      foreach (list_fill[l]) list_fill[l] = 0;

      foreach (directed_tbl[i]) stim_q.insert(stim_q.size(), directed_tbl[i]);
      n_directed = stim_q.size();

      // random data sets: mostly sorted lists, some unsorted, some overfull, some tiny
      e.typed      = 1'b0;
      e.want_value = '0;
      e.want_list  = '0;
      e.want_ovf   = 1'b0;
      while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         order = {};
         for (int l = 0; l < LISTS; l++) begin
            vals[l].delete();
            order.insert(order.size(), l);
         end
         order.shuffle();
         nl    = (kind == 9) ? $urandom_range(1, 2) : $urandom_range(1, LISTS);
         style = $urandom_range(0, 3);
         for (int k = 0; k < nl; k++) begin
            cnt = (kind == 9) ? 1 : $urandom_range(1, DEPTH);
            if (kind == 8 && k == 0) cnt = DEPTH + $urandom_range(1, 4);
            repeat (cnt) begin
               case (style)
                  0: v = $urandom;
                  1: v = int'($urandom_range(0, 16)) - 8;
                  2: v = $urandom_range(0, 1) ? int'(VMIN) + int'($urandom_range(0, 3))
                                              : int'(VMAX) - int'($urandom_range(0, 3));
                  default: begin
                     if ($urandom_range(0, 7) == 0)
                        v = $urandom_range(0, 1) ? int'(VMIN) : int'(VMAX);
                     else
                        v = $urandom;
                  end
               endcase
               vals[order[k]].insert(vals[order[k]].size(), v);
            end
            if (kind != 7) vals[order[k]].sort();
         end
         while (1) begin
            cand.delete();
            for (int l = 0; l < LISTS; l++)
               if (vals[l].size() != 0) cand.insert(cand.size(), l);
            if (cand.size() == 0) break;
            pick    = cand[$urandom_range(0, cand.size() - 1)];
            e.value = vals[pick].pop_front();
            e.list  = IDX_W'(pick);
            e.last  = 1'b0;
            stim_q.insert(stim_q.size(), e);
         end
         stim_q[stim_q.size()-1].last = 1'b1;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      burst_left = 0;
      foreach (stim_q[i]) begin
         // hold off until every pending result has drained
         if (i == n_directed || (i > 0 && stim_q[i-1].last && $urandom_range(0, 5) == 0)) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            while (merged_due.size() != 0) @(posedge clock);
         end
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               @(negedge clock);
               req_chan.valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
         @(negedge clock);
         req_chan.valid      <= 1'b1;
         req_chan.value      <= stim_q[i].value;
         req_chan.list_index <= stim_q[i].list;
         req_chan.load_last  <= stim_q[i].last;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         predict_merge(stim_q[i].value, stim_q[i].list, stim_q[i].last, run);
         if (stim_q[i].typed)
            merged_due.insert(merged_due.size(),
                              merged_type'{stim_q[i].want_value, stim_q[i].want_list, 1'b1,
                                           stim_q[i].want_ovf});
         else
            foreach (run[k]) merged_due.insert(merged_due.size(), run[k]);
         items_sent++;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (merged_due.size() != 0) @(posedge clock);
      repeat (4 * LISTS) @(posedge clock);

      $display("sent %0d elements in %0d data sets (%0d with dropped elements),",
               items_sent, sets_merged, overflow_runs);
      $display("checked %0d merged results under random sender gaps and receiver stalls",
               results_checked);
      if (fail_count == 0)
         $display("k_way_sorted_merge_top regression: pass");
      else
         $display("k_way_sorted_merge_top regression: fail");
      $finish;
   end

endmodule
